// ----- hdl/line_segment_rasterizer_assert.svh -----
// Assertion macros for the line segment rasterizer.
`ifndef LINE_SEGMENT_RASTERIZER_ASSERT_SVH
`define LINE_SEGMENT_RASTERIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define LSR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("line_segment_rasterizer: assertion failed");
`define LSR_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("line_segment_rasterizer: assertion failed");
`else
`define LSR_ASSERT(lbl, clk, rst_n, prop)
`define LSR_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// ----- hdl/lsr_pkg.sv -----
// Package with the types and constants of the line segment rasterizer.
`timescale 1ns / 1ps
package lsr_pkg;

  localparam int COORD_BITS = 16;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0]   diff_t;
  typedef logic        [COORD_BITS-1:0] mag_t;
  typedef logic        [COORD_BITS:0]   twice_t;
  typedef logic signed [COORD_BITS+1:0] err_t;

  localparam coord_t COORD_ONE       = coord_t'(1);
  localparam coord_t COORD_MINUS_ONE = coord_t'(-1);

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_NEXT  = 1'b1;

  typedef struct packed {
    logic   command;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } cmd_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   pixel_valid;
    logic   last_pixel;
  } pix_t;

  // Step directions and axis kept for a running segment.
  typedef struct packed {
    logic y_major;
    logic y_neg;
    logic x_neg;
  } axis_t;

endpackage

// ----- hdl/lsr_if.sv -----
// Valid/ready channel interfaces for commands and pixels.
`timescale 1ns / 1ps
interface lsr_cmd_if;
  logic          valid;
  logic          ready;
  lsr_pkg::cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lsr_pix_if;
  logic          valid;
  logic          ready;
  lsr_pkg::pix_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/line_segment_rasterizer.sv -----
// Bresenham line segment rasterizer for all eight octants, one pixel per word.
// A pixel word is in the output register in the cycle after its command word
// is accepted. One command word is taken per cycle unless the output stalls.
// The single step (add, compare, select) sits between the segment state and
// the output register. Reset clears the segment state to idle and empties the
// output register; an accepted command word always yields one pixel word.
`timescale 1ns / 1ps
`include "line_segment_rasterizer_assert.svh"
module line_segment_rasterizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  lsr_cmd_if.sink    cmd_i,
  lsr_pix_if.source  pix_o
);

  // Segment state: current pixel, endpoint, error term and step increments.
  lsr_pkg::coord_t cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  lsr_pkg::coord_t tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  lsr_pkg::err_t   err_q, err_d;
  lsr_pkg::twice_t maj2_q, maj2_d, min2_q, min2_d;
  lsr_pkg::axis_t  axis_q, axis_d;
  logic            active_q, active_d;

  // Output register. It is loaded whenever it is empty or being drained, so a
  // new command word can enter in the same cycle that a pixel word leaves.
  logic            out_valid_q;
  lsr_pkg::pix_t   out_q, out_d;
  logic            accept;

  assign cmd_i.ready = !out_valid_q || pix_o.ready;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign pix_o.valid = out_valid_q;
  assign pix_o.data  = out_q;

  // Start command arithmetic.
  lsr_pkg::diff_t  dx, dy, adx_w, ady_w;
  lsr_pkg::mag_t   adx, ady, major_len, minor_len;
  logic            x_major;

  // Next command arithmetic.
  lsr_pkg::coord_t step_x, step_y, nx, ny;
  lsr_pkg::err_t   err_sub, err_add;
  logic            strict, at_end, take_minor;

  always_comb begin
    dx        = lsr_pkg::diff_t'(cmd_i.data.end_x) - lsr_pkg::diff_t'(cmd_i.data.start_x);
    dy        = lsr_pkg::diff_t'(cmd_i.data.end_y) - lsr_pkg::diff_t'(cmd_i.data.start_y);
    adx_w     = dx[lsr_pkg::COORD_BITS] ? -dx : dx;
    ady_w     = dy[lsr_pkg::COORD_BITS] ? -dy : dy;
    // A magnitude never exceeds the unsigned coordinate range.
    adx       = adx_w[lsr_pkg::COORD_BITS-1:0];
    ady       = ady_w[lsr_pkg::COORD_BITS-1:0];
    x_major   = adx >= ady;
    major_len = x_major ? adx : ady;
    minor_len = x_major ? ady : adx;

    step_x = axis_q.x_neg ? lsr_pkg::COORD_MINUS_ONE : lsr_pkg::COORD_ONE;
    step_y = axis_q.y_neg ? lsr_pkg::COORD_MINUS_ONE : lsr_pkg::COORD_ONE;
    nx     = cur_x_q + step_x;
    ny     = cur_y_q + step_y;
    // The error test is strict for a positive x direction. A vertical segment
    // counts as non-positive even though its x sign bit is clear.
    strict = !axis_q.x_neg && (!axis_q.y_major || (min2_q != '0));
    at_end = axis_q.y_major ? (ny == tgt_y_q) : (nx == tgt_x_q);
    // While a segment runs the error stays non-negative, so these fit.
    err_sub    = err_q - lsr_pkg::err_t'({1'b0, min2_q});
    err_add    = err_sub + lsr_pkg::err_t'({1'b0, maj2_q});
    take_minor = strict ? err_sub[lsr_pkg::COORD_BITS+1]
                        : (err_sub[lsr_pkg::COORD_BITS+1] || (err_sub == '0));

    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    tgt_x_d  = tgt_x_q;
    tgt_y_d  = tgt_y_q;
    err_d    = err_q;
    maj2_d   = maj2_q;
    min2_d   = min2_q;
    axis_d   = axis_q;
    active_d = active_q;
    out_d    = '0;

    if (cmd_i.data.command == lsr_pkg::CMD_START) begin
      cur_x_d        = cmd_i.data.start_x;
      cur_y_d        = cmd_i.data.start_y;
      tgt_x_d        = cmd_i.data.end_x;
      tgt_y_d        = cmd_i.data.end_y;
      axis_d.x_neg   = dx[lsr_pkg::COORD_BITS];
      axis_d.y_neg   = dy[lsr_pkg::COORD_BITS];
      axis_d.y_major = !x_major;
      err_d          = lsr_pkg::err_t'({2'b00, major_len});
      maj2_d         = {major_len, 1'b0};
      min2_d         = {minor_len, 1'b0};
      // A zero-length segment is finished with its first pixel.
      active_d          = (dx != '0) || (dy != '0);
      out_d.pixel_x     = cmd_i.data.start_x;
      out_d.pixel_y     = cmd_i.data.start_y;
      out_d.pixel_valid = 1'b1;
      out_d.last_pixel  = !active_d;
    end else if (active_q) begin
      out_d.pixel_valid = 1'b1;
      if (at_end) begin
        // The endpoint is given exactly, whatever the minor axis reached.
        active_d         = 1'b0;
        cur_x_d          = tgt_x_q;
        cur_y_d          = tgt_y_q;
        out_d.pixel_x    = tgt_x_q;
        out_d.pixel_y    = tgt_y_q;
        out_d.last_pixel = 1'b1;
      end else begin
        if (axis_q.y_major) begin
          cur_y_d = ny;
          cur_x_d = take_minor ? nx : cur_x_q;
        end else begin
          cur_x_d = nx;
          cur_y_d = take_minor ? ny : cur_y_q;
        end
        err_d         = take_minor ? err_add : err_sub;
        out_d.pixel_x = cur_x_d;
        out_d.pixel_y = cur_y_d;
      end
    end
    // A next command while idle leaves out_d all zero.
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      tgt_x_q     <= '0;
      tgt_y_q     <= '0;
      err_q       <= '0;
      maj2_q      <= '0;
      min2_q      <= '0;
      axis_q      <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cur_x_q  <= cur_x_d;
        cur_y_q  <= cur_y_d;
        tgt_x_q  <= tgt_x_d;
        tgt_y_q  <= tgt_y_d;
        err_q    <= err_d;
        maj2_q   <= maj2_d;
        min2_q   <= min2_d;
        axis_q   <= axis_d;
        active_q <= active_d;
      end
      if (cmd_i.ready) begin
        out_valid_q <= cmd_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  // A running segment never holds a negative error term.
  `LSR_ASSERT(a_err_nonneg, clk_i, rst_ni, active_q |-> !err_q[lsr_pkg::COORD_BITS+1])
  // Once the endpoint word is registered, the segment is idle.
  `LSR_ASSERT(a_last_idle, clk_i, rst_ni, (out_valid_q && out_q.last_pixel) |-> !active_q)
  // An invalid pixel word carries only zeros.
  `LSR_ASSERT(a_idle_zero, clk_i, rst_ni,
    (out_valid_q && !out_q.pixel_valid) |->
    (out_q.pixel_x == '0 && out_q.pixel_y == '0 && !out_q.last_pixel))
  // A stalled pixel word stays in the output register.
  `LSR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_q && !pix_o.ready, out_valid_q)

endmodule

// ----- verif/testbench.sv -----
// Self-checking bench for the line segment rasterizer, with its own pixel walk predictor.
`timescale 1ns / 1ps
module testbench;
  import lsr_pkg::*;

  localparam int ITEM_GOAL    = 1700;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES = 400000;
  localparam int PRINT_CAP    = 100;

  logic clk;
  logic rst_n;

  lsr_cmd_if cmd_if ();
  lsr_pix_if pix_if ();

  line_segment_rasterizer u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if),
    .pix_o  (pix_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Command words waiting to be offered, and the pixel words they must produce.
  cmd_t cmd_q[$];
  pix_t pixel_due_q[$];

  int   mismatch_count;
  int   queued_words;
  int   cycle_count;
  logic steady;        // when set, neither side idles
  logic hold_kick;     // a one-cycle pulse that starts a long output stall
  int   hold_left;

  // Segment state of the predictor.
  coord_t           pen_x, pen_y, goal_x, goal_y;
  logic signed [18:0] err_acc;
  twice_t           major2, minor2;
  axis_t            dir;
  logic             drawing;

  // Advances the pixel walk by one command word and returns the pixel word it gives.
  function automatic pix_t trace_step(cmd_t c);
    pix_t   px;
    diff_t  dx, dy;
    mag_t   adx, ady;
    coord_t step_x, step_y;
    logic   strict, at_end, minor_go;
    px = '0;
    if (c.command == CMD_START) begin
      pen_x  = c.start_x;
      pen_y  = c.start_y;
      goal_x = c.end_x;
      goal_y = c.end_y;
      dx = {goal_x[COORD_BITS-1], goal_x} - {pen_x[COORD_BITS-1], pen_x};
      dy = {goal_y[COORD_BITS-1], goal_y} - {pen_y[COORD_BITS-1], pen_y};
      adx = dx[COORD_BITS] ? mag_t'(-dx) : mag_t'(dx);
      ady = dy[COORD_BITS] ? mag_t'(-dy) : mag_t'(dy);
      dir.x_neg = dx[COORD_BITS];
      dir.y_neg = dy[COORD_BITS];
      if (adx >= ady) begin
        dir.y_major = 1'b0;
        err_acc = {3'b000, adx};
        major2  = {adx, 1'b0};
        minor2  = {ady, 1'b0};
      end else begin
        dir.y_major = 1'b1;
        err_acc = {3'b000, ady};
        major2  = {ady, 1'b0};
        minor2  = {adx, 1'b0};
      end
      drawing = (dx != 0) || (dy != 0);
      px.pixel_x     = pen_x;
      px.pixel_y     = pen_y;
      px.pixel_valid = 1'b1;
      px.last_pixel  = !drawing;
      return px;
    end
    // A next word with no segment running gives an empty pixel word.
    if (!drawing) begin
      return px;
    end
    step_x = dir.x_neg ? COORD_MINUS_ONE : COORD_ONE;
    step_y = dir.y_neg ? COORD_MINUS_ONE : COORD_ONE;
    // The strict test is used only for rightward walks; a vertical walk with
    // no minor length uses the inclusive one.
    strict = !dir.x_neg && (dir.y_major ? (minor2 != 0) : 1'b1);
    if (dir.y_major) begin
      pen_y  = pen_y + step_y;
      at_end = (pen_y == goal_y);
    end else begin
      pen_x  = pen_x + step_x;
      at_end = (pen_x == goal_x);
    end
    if (at_end) begin
      drawing = 1'b0;
      pen_x   = goal_x;
      pen_y   = goal_y;
      px.pixel_x     = goal_x;
      px.pixel_y     = goal_y;
      px.pixel_valid = 1'b1;
      px.last_pixel  = 1'b1;
      return px;
    end
    err_acc  = err_acc - {2'b00, minor2};
    minor_go = strict ? (err_acc < 0) : (err_acc <= 0);
    if (minor_go) begin
      if (dir.y_major) begin
        pen_x = pen_x + step_x;
      end else begin
        pen_y = pen_y + step_y;
      end
      err_acc = err_acc + {2'b00, major2};
    end
    px.pixel_x     = pen_x;
    px.pixel_y     = pen_y;
    px.pixel_valid = 1'b1;
    px.last_pixel  = 1'b0;
    return px;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < PRINT_CAP) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  // The driver offers the oldest pending word and keeps it steady until taken.
  // The prediction is made at the edge where the word is accepted.
  always @(posedge clk) begin : cmd_driver
    if (!rst_n) begin
      cmd_if.valid <= 1'b0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        pixel_due_q = {pixel_due_q, trace_step(cmd_q.pop_front())};
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (cmd_q.size() != 0 && (steady || $urandom_range(99) >= 15)) begin
          cmd_if.valid <= 1'b1;
          cmd_if.data  <= cmd_q[0];
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // The long output stall is timed here, apart from the handshake logic.
  always @(posedge clk) begin : hold_timer
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // The monitor takes pixel words and checks each against the oldest prediction.
  always @(posedge clk) begin : pix_monitor
    pix_t want;
    if (!rst_n) begin
      pix_if.ready <= 1'b0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        if (pixel_due_q.size() == 0) begin
          report_mismatch("unexpected pixel word, x", int'(pix_if.data.pixel_x), 0);
        end else begin
          want = pixel_due_q.pop_front();
          if (pix_if.data.pixel_x !== want.pixel_x) begin
            report_mismatch("pixel_x", int'(pix_if.data.pixel_x), int'(want.pixel_x));
          end
          if (pix_if.data.pixel_y !== want.pixel_y) begin
            report_mismatch("pixel_y", int'(pix_if.data.pixel_y), int'(want.pixel_y));
          end
          if (pix_if.data.pixel_valid !== want.pixel_valid) begin
            report_mismatch("pixel_valid", int'(pix_if.data.pixel_valid),
                            int'(want.pixel_valid));
          end
          if (pix_if.data.last_pixel !== want.last_pixel) begin
            report_mismatch("last_pixel", int'(pix_if.data.last_pixel),
                            int'(want.last_pixel));
          end
        end
      end
      pix_if.ready <= (hold_left == 0) && (steady || $urandom_range(99) >= 15);
    end
  end

  // A hung block ends the run here.
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL line_segment_rasterizer");
      $finish;
    end
  end

  // Coordinates are mostly random over the whole range, sometimes pinned to a limit.
  function automatic int pick_coord();
    int r;
    r = $urandom_range(99);
    if (r < 5) begin
      return -32768;
    end else if (r < 10) begin
      return 32767;
    end
    return int'(coord_t'($urandom));
  endfunction

  task automatic queue_start(int x0, int y0, int x1, int y1);
    cmd_t c;
    c.command = CMD_START;
    c.start_x = coord_t'(x0);
    c.start_y = coord_t'(y0);
    c.end_x   = coord_t'(x1);
    c.end_y   = coord_t'(y1);
    cmd_q = {cmd_q, c};
    queued_words++;
  endtask

  // Next words carry random junk in the coordinate fields, which must be ignored.
  task automatic queue_next(int count);
    cmd_t c;
    for (int i = 0; i < count; i++) begin
      c.command = CMD_NEXT;
      c.start_x = coord_t'($urandom);
      c.start_y = coord_t'($urandom);
      c.end_x   = coord_t'($urandom);
      c.end_y   = coord_t'($urandom);
      cmd_q = {cmd_q, c};
      queued_words++;
    end
  endtask

  // A whole segment with random content: mostly short, now and then long,
  // with extra weight on axis-aligned and diagonal shapes. Some are cut
  // short by the next start and some run past their end into idle.
  task automatic queue_segment();
    int len, side, r, x0, y0, dxv, dyv, steps;
    r = $urandom_range(99);
    if (r < 70) begin
      len = $urandom_range(12);
    end else if (r < 95) begin
      len = $urandom_range(80, 13);
    end else begin
      len = $urandom_range(300, 81);
    end
    case ($urandom_range(5))
      0:       side = 0;
      1:       side = len;
      default: side = $urandom_range(len);
    endcase
    if ($urandom_range(1) == 0) begin
      dxv = len;
      dyv = side;
    end else begin
      dxv = side;
      dyv = len;
    end
    if ($urandom_range(1) == 0) dxv = -dxv;
    if ($urandom_range(1) == 0) dyv = -dyv;
    x0 = pick_coord();
    y0 = pick_coord();
    if (x0 + dxv > 32767 || x0 + dxv < -32768) dxv = -dxv;
    if (y0 + dyv > 32767 || y0 + dyv < -32768) dyv = -dyv;
    steps = len;
    r = $urandom_range(99);
    if (r < 10) begin
      steps = $urandom_range(len);
    end else if (r < 20) begin
      steps = len + $urandom_range(3, 1);
    end
    queue_start(x0, y0, x0 + dxv, y0 + dyv);
    queue_next(steps);
  endtask

  // Noise: stray next words, or a start anywhere in the plane that is dropped
  // after a few pixels.
  task automatic queue_noise();
    if ($urandom_range(1) == 0) begin
      queue_next($urandom_range(3, 1));
    end else begin
      queue_start(pick_coord(), pick_coord(), pick_coord(), pick_coord());
      queue_next($urandom_range(4));
    end
  endtask

  task automatic wait_drained();
    while (cmd_q.size() != 0 || pixel_due_q.size() != 0) @(negedge clk);
  endtask

  // Stimulus works on the falling edge so that it never races the clocked blocks.
  initial begin : stimulus
    pix_t stray;
    cmd_if.valid   = 1'b0;
    cmd_if.data    = '0;
    pix_if.ready   = 1'b0;
    rst_n          = 1'b0;
    steady         = 1'b0;
    hold_kick      = 1'b0;
    mismatch_count = 0;
    queued_words   = 0;
    cycle_count    = 0;
    pen_x   = '0;
    pen_y   = '0;
    goal_x  = '0;
    goal_y  = '0;
    err_acc = '0;
    major2  = '0;
    minor2  = '0;
    dir     = '0;
    drawing = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed words: next while idle, a zero-length segment and a short one at the
    // corners of the plane, a few octants, a vertical walk abandoned by a new
    // start, a run past the endpoint, and the longest possible diagonal cut short.
    queue_next(1);
    queue_start(-32768, 32767, -32768, 32767);
    queue_next(1);
    queue_start(32767, -32768, 32765, -32767);
    queue_next(2);
    queue_start(0, 0, 1, 3);
    queue_next(3);
    queue_start(5, 5, 5, 8);
    queue_next(1);
    queue_start(0, 0, -2, -2);
    queue_next(3);
    queue_start(-32768, -32768, 32767, 32767);
    queue_next(2);
    queue_start(7, 0, 0, -2);
    queue_next(2);
    // The sender pauses here until every pixel word has come back.
    wait_drained();

    // Stall the output for a long stretch while words keep coming, so the
    // block fills up and pushes back on its input.
    hold_kick = 1'b1;
    @(negedge clk);
    hold_kick = 1'b0;
    while (queued_words < 90) queue_segment();
    while (hold_left != 0) @(negedge clk);
    wait_drained();

    // Random part, with a stretch in the middle where nobody idles.
    while (queued_words < ITEM_GOAL) begin
      steady = (queued_words >= 700) && (queued_words < 1100);
      if ($urandom_range(99) < 85) begin
        queue_segment();
      end else begin
        queue_noise();
      end
      while (cmd_q.size() > 16) @(negedge clk);
    end
    steady = 1'b0;
    wait_drained();
    repeat (4) @(negedge clk);

    while (pixel_due_q.size() != 0) begin
      stray = pixel_due_q.pop_front();
      report_mismatch("missing pixel word, x", 0, int'(stray.pixel_x));
    end
    if (mismatch_count == 0) begin
      $display("PASS line_segment_rasterizer");
    end else begin
      $display("FAIL line_segment_rasterizer");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/lsr_pkg.sv
hdl/lsr_if.sv
hdl/line_segment_rasterizer.sv
verif/testbench.sv
